// ===== rtl/m3i_pkg.sv =====
// Shared constants for the 3x3 matrix inverse: defaults and cofactor source table.
package m3i_pkg;

   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_ENTRY_WIDTH = 24;
   localparam int NUM_ENTRIES     = 9;

   typedef logic [3:0] idx_type;

   // cofactor j = x[s0]*x[s1] - x[s2]*x[s3], already transposed (adjugate order)
   localparam idx_type COF_SRC [NUM_ENTRIES][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

// ===== rtl/m3i_channels.sv =====
// Request and response channel interfaces of the 3x3 matrix inverse.
interface m3i_req_if #(parameter int ENTRY_WIDTH = m3i_pkg::DEF_ENTRY_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] in_r0c0, in_r0c1, in_r0c2;
   logic signed [ENTRY_WIDTH-1:0] in_r1c0, in_r1c1, in_r1c2;
   logic signed [ENTRY_WIDTH-1:0] in_r2c0, in_r2c1, in_r2c2;

   modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, input ready);
   modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_rsp_if #(parameter int ENTRY_WIDTH = m3i_pkg::DEF_ENTRY_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] out_r0c0, out_r0c1, out_r0c2;
   logic signed [ENTRY_WIDTH-1:0] out_r1c0, out_r1c1, out_r1c2;
   logic signed [ENTRY_WIDTH-1:0] out_r2c0, out_r2c1, out_r2c2;
   logic                          singular;
   logic                          saturated;

   modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                   input ready);
   modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                   output ready);
endinterface

// ===== rtl/matrix3_inverse.sv =====
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | in_r0c0 .. in_r2c2
//   rsp     | out | valid/ready | out_r0c0 .. out_r2c2, singular, saturated
//
// One matrix enters per cycle while req.ready is high. Seven arithmetic stages
// are followed by the divider lanes, which resolve one quotient bit per stage,
// and an output register. Each stage holds its beat until the next one frees,
// so bubbles collapse and req.ready falls only when every stage is full and rsp
// stalls. Reset clears the stage valid bits only.
module matrix3_inverse #(
   parameter int FRAC_BITS   = m3i_pkg::DEF_FRAC_BITS,
   parameter int ENTRY_WIDTH = m3i_pkg::DEF_ENTRY_WIDTH
) (
   input logic       clock,
   input logic       reset,
   m3i_req_if.sink   req,
   m3i_rsp_if.source rsp
);
   import m3i_pkg::*;

   localparam int W   = ENTRY_WIDTH;
   localparam int PW  = 2 * W;
   localparam int CW  = 2 * W + 1;
   localparam int CM  = 2 * W;
   localparam int DPW = 2 * W + 1;
   localparam int FPW = 3 * W + 1;
   localparam int DTW = 3 * W + 3;
   localparam int DMW = 3 * W + 2;
   localparam int SHW = 2 * W + 2 * FRAC_BITS + 1;
   localparam int NW  = ((SHW > DMW) ? SHW : DMW) + 1;
   localparam int DW  = DMW + 1;

   localparam int S_DIV = 7;
   localparam int LS    = W + 1;
   localparam int NS    = S_DIV + LS + 1;

   localparam logic [W-1:0] LIM_NEG  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] LIM_POS  = ~LIM_NEG;
   localparam bit           DIAG_SAT = FRAC_BITS >= W - 1;
   localparam logic [W-1:0] DIAG     = DIAG_SAT ? LIM_POS : (W'(1) << FRAC_BITS);

   logic [NS:0]   en;
   logic [NS-1:0] v_ff, v_in;

   assign en[NS] = rsp.ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign v_in = {v_ff[NS-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   assign req.ready = en[0];
   assign rsp.valid = v_ff[NS-1];

   logic signed [W-1:0] x [NUM_ENTRIES];
   assign x[0] = req.in_r0c0;
   assign x[1] = req.in_r0c1;
   assign x[2] = req.in_r0c2;
   assign x[3] = req.in_r1c0;
   assign x[4] = req.in_r1c1;
   assign x[5] = req.in_r1c2;
   assign x[6] = req.in_r2c0;
   assign x[7] = req.in_r2c1;
   assign x[8] = req.in_r2c2;

   logic signed [PW-1:0]  pa_ff [NUM_ENTRIES];
   logic signed [PW-1:0]  pb_ff [NUM_ENTRIES];
   logic signed [W-1:0]   row0_ff [3];
   logic signed [W-1:0]   row1_ff [3];
   logic signed [CW-1:0]  cof1_ff [NUM_ENTRIES];
   logic signed [CW-1:0]  cof2_ff [NUM_ENTRIES];
   logic signed [CW-1:0]  cof3_ff [NUM_ENTRIES];
   logic signed [CW-1:0]  cof4_ff [NUM_ENTRIES];
   logic signed [DPW-1:0] dlo_ff [3];
   logic signed [DPW-1:0] dhi_ff [3];
   logic signed [FPW-1:0] dp_ff [3];
   logic signed [DTW-1:0] det_ff;
   logic [DMW-1:0]        dmag_ff;
   logic [CM-1:0]         cm_ff [NUM_ENTRIES];
   logic                  neg5_ff [NUM_ENTRIES];
   logic                  zero5_ff;
   logic [NW-1:0]         num_ff [NUM_ENTRIES];
   logic [DW-1:0]         dd_ff;
   logic                  neg6_ff [NUM_ENTRIES];
   logic                  zero6_ff;

   // products of the cofactor terms
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            pa_ff[j] <= x[COF_SRC[j][0]] * x[COF_SRC[j][1]];
            pb_ff[j] <= x[COF_SRC[j][2]] * x[COF_SRC[j][3]];
         end
         for (int r = 0; r < 3; r++) row0_ff[r] <= x[r];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            cof1_ff[j] <= CW'(pa_ff[j]) - CW'(pb_ff[j]);
         end
         row1_ff <= row0_ff;
      end
   end

   // determinant terms: split the cofactor into low and high halves
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int r = 0; r < 3; r++) begin
            dlo_ff[r] <= row1_ff[r] * $signed({1'b0, cof1_ff[3*r][W-1:0]});
            dhi_ff[r] <= row1_ff[r] * $signed(cof1_ff[3*r][CW-1:W]);
         end
         cof2_ff <= cof1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int r = 0; r < 3; r++) begin
            dp_ff[r] <= (FPW'(dhi_ff[r]) <<< W) + FPW'(dlo_ff[r]);
         end
         cof3_ff <= cof2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         det_ff  <= DTW'(dp_ff[0]) + DTW'(dp_ff[1]) + DTW'(dp_ff[2]);
         cof4_ff <= cof3_ff;
      end
   end

   logic [DTW-1:0] det_abs;
   logic [CW-1:0]  cof_abs [NUM_ENTRIES];

   always_comb begin
      det_abs = det_ff[DTW-1] ? DTW'(-det_ff) : DTW'(det_ff);
      for (int j = 0; j < NUM_ENTRIES; j++) begin
         cof_abs[j] = cof4_ff[j][CW-1] ? CW'(-cof4_ff[j]) : CW'(cof4_ff[j]);
      end
   end

   // sign and magnitude split
   always_ff @(posedge clock) begin
      if (en[5]) begin
         zero5_ff <= det_ff == '0;
         dmag_ff  <= det_abs[DMW-1:0];
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            cm_ff[j]   <= cof_abs[j][CM-1:0];
            neg5_ff[j] <= cof4_ff[j][CW-1] ^ det_ff[DTW-1];
         end
      end
   end

   // rounding numerator: 2*|cof|*2^(2F) + |det| over 2*|det|
   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            num_ff[j] <= (NW'(cm_ff[j]) << (2 * FRAC_BITS + 1)) + NW'(dmag_ff);
         end
         dd_ff    <= {dmag_ff, 1'b0};
         neg6_ff  <= neg5_ff;
         zero6_ff <= zero5_ff;
      end
   end

   logic [W-1:0] quot [NUM_ENTRIES];
   logic         ovf  [NUM_ENTRIES];

   for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_lane
      m3i_div_lane #(.QW(W), .NW(NW), .DW(DW)) u_lane (
         .clock (clock),
         .en    (en[S_DIV +: LS]),
         .num   (num_ff[j]),
         .den   (dd_ff),
         .quot  (quot[j]),
         .ovf   (ovf[j])
      );
   end

   logic neg_s_ff  [LS][NUM_ENTRIES];
   logic zero_s_ff [LS];

   // carry signs and singular flag alongside the divider lanes
   always_ff @(posedge clock) begin
      for (int s = 0; s < LS; s++) begin
         if (en[S_DIV + s]) begin
            if (s == 0) begin
               neg_s_ff[s]  <= neg6_ff;
               zero_s_ff[s] <= zero6_ff;
            end else begin
               neg_s_ff[s]  <= neg_s_ff[s-1];
               zero_s_ff[s] <= zero_s_ff[s-1];
            end
         end
      end
   end

   logic [W-1:0] res_in [NUM_ENTRIES];
   logic         sat_in;
   logic [W-1:0] res_ff [NUM_ENTRIES];
   logic         sing_ff, sat_ff;

   always_comb begin
      logic [W-1:0] lim, mag;
      logic         clip;
      sat_in = 1'b0;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
         lim  = neg_s_ff[LS-1][j] ? LIM_NEG : LIM_POS;
         clip = ovf[j] || (quot[j] > lim);
         mag  = clip ? lim : quot[j];
         if (zero_s_ff[LS-1]) begin
            res_in[j] = (j % 4 == 0) ? DIAG : '0;
         end else begin
            res_in[j] = neg_s_ff[LS-1][j] ? W'(-mag) : mag;
            sat_in    = sat_in | clip;
         end
      end
      if (zero_s_ff[LS-1]) sat_in = DIAG_SAT;
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         res_ff  <= res_in;
         sing_ff <= zero_s_ff[LS-1];
         sat_ff  <= sat_in;
      end
   end

   assign rsp.out_r0c0  = res_ff[0];
   assign rsp.out_r0c1  = res_ff[1];
   assign rsp.out_r0c2  = res_ff[2];
   assign rsp.out_r1c0  = res_ff[3];
   assign rsp.out_r1c1  = res_ff[4];
   assign rsp.out_r1c2  = res_ff[5];
   assign rsp.out_r2c0  = res_ff[6];
   assign rsp.out_r2c1  = res_ff[7];
   assign rsp.out_r2c2  = res_ff[8];
   assign rsp.singular  = sing_ff;
   assign rsp.saturated = sat_ff;

endmodule

// ===== rtl/m3i_div_lane.sv =====
// Pipelined restoring divider lane: overflow check then one quotient bit per stage.
module m3i_div_lane #(
   parameter int QW = 24,
   parameter int NW = 82,
   parameter int DW = 75
) (
   input  logic          clock,
   input  logic [QW:0]   en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quot,
   output logic          ovf
);

   localparam int XW = (NW > DW + QW) ? NW : DW + QW;

   logic [XW-1:0] r_ff   [QW+1];
   logic [DW-1:0] d_ff   [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ovf_ff [QW+1];

   // quotient must fit QW bits, otherwise the overflow flag is set and carried along
   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= XW'(num);
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= XW'(num) >= (XW'(den) << QW);
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_step
      localparam int BIT = QW - s;
      logic [XW-1:0] sub;
      logic          ge;

      assign sub = XW'(d_ff[s-1]) << BIT;
      assign ge  = r_ff[s-1] >= sub;

      always_ff @(posedge clock) begin
         if (en[s]) begin
            r_ff[s]   <= ge ? r_ff[s-1] - sub : r_ff[s-1];
            d_ff[s]   <= d_ff[s-1];
            q_ff[s]   <= q_ff[s-1] | (QW'(ge) << BIT);
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign quot = q_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule
